// File: design/wvn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wvn_pkg;

    localparam int DEF_MAX_SECTIONS = 1024;
    localparam int DEF_SINE_DEPTH   = 1024;

    // Angle constants: 2*pi and pi/2 in Q30, 2^32/(2*pi) for the turn phase.
    localparam longint unsigned TWO_PI_Q30     = 64'd6746518852;
    localparam longint unsigned INV_TWO_PI_Q32 = 64'd683565276;
    localparam longint unsigned HALF_PI_Q30    = 64'd1686629713;
    localparam longint unsigned ONE_Q30        = 64'd1073741824;
    localparam logic [15:0]     SEVEN_TENTHS_Q16 = 16'd45875;

    // Reciprocals used to estimate the quotient of an angle by its modulus.
    localparam longint unsigned RECIP_NEAR = (64'd1 << 51) / TWO_PI_Q30;
    localparam longint unsigned RECIP_FAR  = (64'd1 << 51) / (2 * TWO_PI_Q30);

    localparam int HGT_LAT  = 14;
    localparam int NRM_LAT  = 56;
    localparam int SIDE_LEN = HGT_LAT + NRM_LAT + 2;

    typedef enum logic [2:0] {
        CFG_PHASE_X       = 3'd0,
        CFG_PHASE_Y       = 3'd1,
        CFG_WAVE_SCALE    = 3'd2,
        CFG_AMPLITUDE     = 3'd3,
        CFG_CELL_LENGTH   = 3'd4,
        CFG_CELL_WIDTH    = 3'd5,
        CFG_SECTIONS_LONG = 3'd6,
        CFG_SECTIONS_WIDE = 3'd7
    } t_cfg_idx;

    localparam logic [15:0] RST_WAVE_SCALE    = 16'd1638;
    localparam logic [23:0] RST_AMPLITUDE     = 24'd25600;
    localparam logic [23:0] RST_CELL_LENGTH   = 24'd2560;
    localparam logic [23:0] RST_CELL_WIDTH    = 24'd2560;
    localparam logic [10:0] RST_SECTIONS_LONG = 11'd16;
    localparam logic [10:0] RST_SECTIONS_WIDE = 11'd16;

    typedef struct packed {
        logic signed [31:0] phase_x;
        logic signed [31:0] phase_y;
        logic signed [31:0] px7;
        logic signed [31:0] py7;
        logic [15:0]        scale;
        logic [23:0]        amp;
    } t_wave_cfg;

    typedef struct packed {
        logic [33:0] pos_x;
        logic [33:0] pos_y;
        logic        outside;
        logic        empty;
    } t_side;

    // Odd polynomial sine of a Q30 angle in the first quadrant, result Q1.14.
    function automatic logic [14:0] f_poly_sine(longint unsigned x);
        longint unsigned x2;
        longint unsigned p;
        longint unsigned r;
        x2 = (x * x) >> 30;
        p  = ONE_Q30;
        p  = ONE_Q30 - ((x2 * p) >> 30) / 110;
        p  = ONE_Q30 - ((x2 * p) >> 30) / 72;
        p  = ONE_Q30 - ((x2 * p) >> 30) / 42;
        p  = ONE_Q30 - ((x2 * p) >> 30) / 20;
        p  = ONE_Q30 - ((x2 * p) >> 30) / 6;
        r  = (x * p + (64'd1 << 45)) >> 46;
        if (r > 64'd16384) begin
            r = 64'd16384;
        end
        return r[14:0];
    endfunction

endpackage
`default_nettype wire

// File: design/wvn_height.sv
`timescale 1ns / 1ps
`default_nettype none
module wvn_height #(
    parameter int SINE_DEPTH = wvn_pkg::DEF_SINE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic [10:0]        i_x,
    input  wire logic [10:0]        i_y,
    input  wire wvn_pkg::t_wave_cfg i_cfg,
    output logic signed [24:0]      o_h
);

    localparam int IdxW = $clog2(SINE_DEPTH + 1);
    localparam longint unsigned ModNear = wvn_pkg::TWO_PI_Q30;
    localparam longint unsigned ModFar  = 2 * wvn_pkg::TWO_PI_Q30;

    typedef logic [14:0] t_rom [0:SINE_DEPTH];

    function automatic t_rom f_build_rom();
        t_rom rom;
        for (int i = 0; i <= SINE_DEPTH; i++) begin
            rom[i] = wvn_pkg::f_poly_sine((wvn_pkg::HALF_PI_Q30 * 64'(i)) / SINE_DEPTH);
        end
        return rom;
    endfunction

    localparam t_rom SineRom = f_build_rom();

    // Lanes: 0 cos(A1), 1 sin(B1), 2 cos(A2), 3 sin(B2). Lanes 2 and 3 carry
    // the factor 2.5 as *5 over a doubled modulus.
    logic signed [33:0] r_s    [4];
    logic signed [53:0] r_t    [4];
    logic [51:0]        r_ta   [4];
    logic [51:0]        r_ta4  [4];
    logic [18:0]        r_qe   [4];
    logic [35:0]        r_re   [4];
    logic [33:0]        r_rc   [4];
    logic [33:0]        r_r    [4];
    logic [31:0]        r_turn [4];
    logic [IdxW-1:0]    r_idx  [4];
    logic [14:0]        r_sv   [4];
    logic [3:0]         r_tn3, r_tn4, r_tn5, r_tn6;
    logic [3:0]         r_ineg, r_sneg;
    logic signed [31:0] r_pa, r_pb, r_sum;
    logic signed [55:0] r_hp;
    logic signed [24:0] r_h;

    logic signed [33:0] n_s    [4];
    logic signed [53:0] n_t5   [4];
    logic [51:0]        n_ta   [4];
    logic [3:0]         n_tn;
    logic [18:0]        n_qe   [4];
    logic [35:0]        n_re   [4];
    logic [33:0]        n_rc   [4];
    logic [33:0]        n_r    [4];
    logic [31:0]        n_turn [4];
    logic [IdxW-1:0]    n_idx  [4];
    logic [3:0]         n_ineg;
    logic signed [15:0] n_v    [4];
    logic signed [55:0] n_hr;
    logic signed [26:0] n_hs;
    logic signed [24:0] n_h;

    always_comb begin
        n_s[0] = $signed({7'b0, i_x, 16'b0}) + 34'(i_cfg.phase_x);
        n_s[1] = $signed({7'b0, i_y, 16'b0}) + 34'(i_cfg.phase_y);
        n_s[2] = $signed({7'b0, i_x, 16'b0}) + 34'(i_cfg.px7);
        n_s[3] = $signed({7'b0, i_y, 16'b0}) - 34'(i_cfg.py7);
    end

    always_comb begin
        logic [63:0] v_prod;
        logic [63:0] v_mod;
        logic [63:0] v_rem;
        logic [47:0] v_ip;
        logic [17:0] v_raw;
        logic [31:0] v_ph;
        for (int l = 0; l < 4; l++) begin
            v_mod = (l >= 2) ? ModFar : ModNear;
            // Stage 3: scale and magnitude.
            n_t5[l] = (l >= 2) ? (r_t[l] <<< 2) + r_t[l] : r_t[l];
            n_tn[l] = n_t5[l][53];
            n_ta[l] = n_tn[l] ? 52'(-n_t5[l]) : 52'(n_t5[l]);
            // Stage 4: quotient estimate, at most three short of the truth.
            v_prod  = 64'(r_ta[l][51:20]) * ((l >= 2) ? wvn_pkg::RECIP_FAR
                                                      : wvn_pkg::RECIP_NEAR);
            n_qe[l] = 19'(v_prod >> 31);
            // Stage 5: remainder estimate, below four moduli.
            v_rem   = 64'(r_ta4[l]) - 64'(r_qe[l]) * v_mod;
            n_re[l] = v_rem[35:0];
            // Stage 6: two correction steps.
            v_rem = 64'(r_re[l]);
            if (v_rem >= 2 * v_mod) begin
                v_rem = v_rem - 2 * v_mod;
            end
            if (v_rem >= v_mod) begin
                v_rem = v_rem - v_mod;
            end
            n_rc[l] = v_rem[33:0];
            // Stage 7: a negative angle wraps to the positive remainder.
            v_rem  = v_mod - 64'(r_rc[l]);
            n_r[l] = (r_tn6[l] && (r_rc[l] != 34'd0)) ? v_rem[33:0] : r_rc[l];
            // Stage 8: turn phase.
            v_prod    = 64'(r_r[l]) * wvn_pkg::INV_TWO_PI_Q32;
            n_turn[l] = (l >= 2) ? v_prod[62:31] : v_prod[61:30];
            // Stage 9: quarter-wave table index.
            v_ph  = r_turn[l] + (((l % 2) == 0) ? 32'h4000_0000 : 32'h0);
            v_ip  = 48'(v_ph[29:0]) * 48'(SINE_DEPTH) + 48'(64'd1 << 29);
            v_raw = v_ip[47:30];
            if (32'(v_raw) > 32'(SINE_DEPTH)) begin
                v_raw = 18'(SINE_DEPTH);
            end
            n_idx[l]  = v_ph[30] ? IdxW'(SINE_DEPTH) - IdxW'(v_raw) : IdxW'(v_raw);
            n_ineg[l] = v_ph[31];
            // Stage 11 input: signed table value.
            n_v[l] = r_sneg[l] ? -$signed({1'b0, r_sv[l]}) : $signed({1'b0, r_sv[l]});
        end
    end

    always_comb begin
        n_hr = r_hp + 56'sd268435456;
        n_hs = 27'(n_hr >>> 29);
        if (n_hs > 27'sd16777215) begin
            n_h = 25'sd16777215;
        end else if (n_hs < -27'sd16777216) begin
            n_h = -25'sd16777216;
        end else begin
            n_h = 25'(n_hs);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 4; l++) begin
            r_s[l]    <= n_s[l];
            r_t[l]    <= 54'(r_s[l]) * 54'($signed({1'b0, i_cfg.scale}));
            r_ta[l]   <= n_ta[l];
            r_ta4[l]  <= r_ta[l];
            r_qe[l]   <= n_qe[l];
            r_re[l]   <= n_re[l];
            r_rc[l]   <= n_rc[l];
            r_r[l]    <= n_r[l];
            r_turn[l] <= n_turn[l];
            r_idx[l]  <= n_idx[l];
            r_sv[l]   <= SineRom[r_idx[l]];
        end
        r_tn3  <= n_tn;
        r_tn4  <= r_tn3;
        r_tn5  <= r_tn4;
        r_tn6  <= r_tn5;
        r_ineg <= n_ineg;
        r_sneg <= r_ineg;
        r_pa   <= 32'(n_v[0]) * 32'(n_v[1]);
        r_pb   <= 32'(n_v[2]) * 32'(n_v[3]);
        r_sum  <= r_pa + r_pb;
        r_hp   <= 56'(r_sum) * 56'($signed({1'b0, i_cfg.amp}));
        r_h    <= n_h;
    end

    assign o_h = r_h;

endmodule
`default_nettype wire

// File: design/wvn_normal.sv
`timescale 1ns / 1ps
`default_nettype none
module wvn_normal (
    input  wire logic               i_clk,
    input  wire logic signed [25:0] i_uz,
    input  wire logic signed [25:0] i_vz,
    input  wire logic [23:0]        i_cell_length,
    input  wire logic [23:0]        i_cell_width,
    input  wire logic               i_zero,
    output logic signed [15:0]      o_nx,
    output logic signed [15:0]      o_ny,
    output logic [14:0]             o_nz
);

    typedef struct packed {
        logic [61:0]       n;
        logic [62:0]       res;
        logic [2:0][29:0]  m;
        logic [2:0]        neg;
        logic              degen;
    } t_isq;

    typedef struct packed {
        logic [2:0][44:0] rem;
        logic [2:0][14:0] q;
        logic [30:0]      len;
        logic [2:0]       neg;
        logic             degen;
    } t_div;

    logic signed [50:0] r_c0, r_c1;
    logic [47:0]        r_c2;
    logic               r_z1, r_z2, r_z3, r_z4, r_z5, r_z6;
    logic [2:0][49:0]   r_mag, r_mag3, r_mag4;
    logic [2:0]         r_neg2, r_neg3, r_neg4, r_neg5, r_neg6;
    logic [49:0]        r_maxm;
    logic [4:0]         r_sh, r_sh5, r_sh6;
    logic [2:0][29:0]   r_m, r_m6;
    logic [2:0][59:0]   r_sqr;
    t_isq               r_isq [0:32];
    t_div               r_div [0:15];
    logic signed [15:0] r_nx, r_ny;
    logic [14:0]        r_nz;

    logic [5:0]         n_bl;
    logic [4:0]         n_sh;
    logic [61:0]        n_sq;
    t_isq               n_isq [0:32];
    t_div               n_div [0:15];
    logic [15:0]        n_q   [3];
    logic signed [15:0] n_n   [3];

    always_comb begin
        n_bl = 6'd0;
        for (int i = 0; i < 50; i++) begin
            if (r_maxm[i]) begin
                n_bl = 6'(i + 1);
            end
        end
        n_sh = (n_bl > 6'd30) ? 5'(n_bl - 6'd30) : 5'd0;
    end

    always_comb begin
        n_sq = 62'(r_sqr[0]) + 62'(r_sqr[1]) + 62'(r_sqr[2]);
        n_isq[0].n     = n_sq;
        n_isq[0].res   = 63'd0;
        n_isq[0].m     = r_m6;
        n_isq[0].neg   = r_neg6;
        // A vanishing cross product gives no direction.
        n_isq[0].degen = r_z6 || ((r_sh6 == 5'd0) && (n_sq <= 62'd42));
    end

    // Square root, one result bit per stage.
    always_comb begin
        logic [63:0] v_bit;
        logic [63:0] v_try;
        for (int k = 1; k <= 32; k++) begin
            v_bit    = 64'd1 << (62 - 2 * (k - 1));
            v_try    = 64'(r_isq[k-1].res) + v_bit;
            n_isq[k] = r_isq[k-1];
            if (64'(r_isq[k-1].n) >= v_try) begin
                n_isq[k].n   = 62'(64'(r_isq[k-1].n) - v_try);
                n_isq[k].res = 63'(64'(r_isq[k-1].res >> 1) + v_bit);
            end else begin
                n_isq[k].res = r_isq[k-1].res >> 1;
            end
        end
    end

    always_comb begin
        n_div[0].len   = r_isq[32].res[30:0];
        n_div[0].neg   = r_isq[32].neg;
        n_div[0].degen = r_isq[32].degen || (r_isq[32].res[30:0] == 31'd0);
        for (int i = 0; i < 3; i++) begin
            n_div[0].rem[i] = {1'b0, r_isq[32].m[i], 14'b0}
                              + 45'(r_isq[32].res[30:1]);
            n_div[0].q[i]   = 15'd0;
        end
    end

    // Restoring division, one quotient bit per stage, three lanes.
    always_comb begin
        logic [44:0] v_d;
        for (int j = 1; j <= 15; j++) begin
            n_div[j] = r_div[j-1];
            v_d      = 45'(r_div[j-1].len) << (15 - j);
            for (int i = 0; i < 3; i++) begin
                if (r_div[j-1].rem[i] >= v_d) begin
                    n_div[j].rem[i]       = r_div[j-1].rem[i] - v_d;
                    n_div[j].q[i][15 - j] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_q[i] = (r_div[15].q[i] > 15'd16384) ? 16'd16384 : 16'(r_div[15].q[i]);
            if (r_div[15].degen) begin
                n_n[i] = 16'sd0;
            end else if (r_div[15].neg[i]) begin
                n_n[i] = -$signed(n_q[i]);
            end else begin
                n_n[i] = $signed(n_q[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c0 <= 51'($signed({1'b0, i_cell_width})) * 51'(i_uz);
        r_c1 <= 51'($signed({1'b0, i_cell_length})) * 51'(i_vz);
        r_c2 <= 48'(i_cell_length) * 48'(i_cell_width);
        r_z1 <= i_zero;

        r_mag[0] <= r_c0[50] ? 50'(-r_c0) : 50'(r_c0);
        r_mag[1] <= r_c1[50] ? 50'(-r_c1) : 50'(r_c1);
        r_mag[2] <= 50'(r_c2);
        r_neg2   <= {1'b0, r_c1[50], r_c0[50]};
        r_z2     <= r_z1;

        r_maxm <= (r_mag[0] > r_mag[1])
                  ? ((r_mag[0] > r_mag[2]) ? r_mag[0] : r_mag[2])
                  : ((r_mag[1] > r_mag[2]) ? r_mag[1] : r_mag[2]);
        r_mag3 <= r_mag;
        r_neg3 <= r_neg2;
        r_z3   <= r_z2;

        r_sh   <= n_sh;
        r_mag4 <= r_mag3;
        r_neg4 <= r_neg3;
        r_z4   <= r_z3;

        for (int i = 0; i < 3; i++) begin
            r_m[i]   <= 30'(r_mag4[i] >> r_sh);
            r_sqr[i] <= 60'(r_m[i]) * 60'(r_m[i]);
        end
        r_sh5  <= r_sh;
        r_neg5 <= r_neg4;
        r_z5   <= r_z4;

        r_m6   <= r_m;
        r_sh6  <= r_sh5;
        r_neg6 <= r_neg5;
        r_z6   <= r_z5;

        for (int k = 0; k <= 32; k++) begin
            r_isq[k] <= n_isq[k];
        end
        for (int j = 0; j <= 15; j++) begin
            r_div[j] <= n_div[j];
        end

        r_nx <= n_n[0];
        r_ny <= n_n[1];
        r_nz <= n_n[2][14:0];
    end

    assign o_nx = r_nx;
    assign o_ny = r_ny;
    assign o_nz = r_nz;

endmodule
`default_nettype wire

// File: design/wave_heightfield_vertex_normal.sv
`timescale 1ns / 1ps
`default_nettype none
// Each vertex yields one result beat after its start beat; a new vertex may
// start in every cycle, so throughput is one vertex per cycle. The pipeline
// depth is set mostly by the bit-per-stage square root and divider of the normal.
// busy is always low and results leave on the o_valid strobe, which the
// receiver cannot stall. Reset empties the pipeline and loads register defaults.
module wave_heightfield_vertex_normal #(
    parameter int MAX_SECTIONS = wvn_pkg::DEF_MAX_SECTIONS,
    parameter int SINE_DEPTH   = wvn_pkg::DEF_SINE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [10:0]        i_vertex_x,
    input  wire logic [10:0]        i_vertex_y,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    output logic                    o_valid,
    output logic [33:0]             o_pos_x,
    output logic [33:0]             o_pos_y,
    output logic signed [24:0]      o_height,
    output logic signed [15:0]      o_normal_x,
    output logic signed [15:0]      o_normal_y,
    output logic [14:0]             o_normal_z,
    output logic                    o_outside_grid
);

    localparam int SideLen = wvn_pkg::SIDE_LEN;

    wvn_pkg::t_wave_cfg r_cfg;
    logic [23:0]        r_cell_length, r_cell_width;
    logic [10:0]        r_sections_long, r_sections_wide;

    logic [10:0]        r_hx [4];
    logic [10:0]        r_hy [4];
    wvn_pkg::t_side     r_side [0:SideLen-1];
    logic [SideLen-1:0] r_vld;
    logic signed [25:0] r_uz, r_vz;
    logic signed [24:0] r_hd [0:wvn_pkg::NRM_LAT];
    logic               r_valid;

    logic signed [47:0] n_px7, n_py7;
    logic [10:0]        n_l, n_w, n_a, n_b;
    logic               n_empty;
    logic [34:0]        n_px, n_py;
    wvn_pkg::t_side     n_side;
    logic signed [24:0] w_h [4];
    logic signed [15:0] w_nx, w_ny;
    logic [14:0]        w_nz;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_px7 = ($signed(i_cfg_data) * $signed({1'b0, wvn_pkg::SEVEN_TENTHS_Q16})
                 + 48'sd32768) >>> 16;
        n_py7 = n_px7;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_x   <= 32'sd0;
            r_cfg.phase_y   <= 32'sd0;
            r_cfg.px7       <= 32'sd0;
            r_cfg.py7       <= 32'sd0;
            r_cfg.scale     <= wvn_pkg::RST_WAVE_SCALE;
            r_cfg.amp       <= wvn_pkg::RST_AMPLITUDE;
            r_cell_length   <= wvn_pkg::RST_CELL_LENGTH;
            r_cell_width    <= wvn_pkg::RST_CELL_WIDTH;
            r_sections_long <= wvn_pkg::RST_SECTIONS_LONG;
            r_sections_wide <= wvn_pkg::RST_SECTIONS_WIDE;
        end else if (i_cfg_valid) begin
            case (wvn_pkg::t_cfg_idx'(i_cfg_index))
                wvn_pkg::CFG_PHASE_X: begin
                    r_cfg.phase_x <= $signed(i_cfg_data);
                    r_cfg.px7     <= n_px7[31:0];
                end
                wvn_pkg::CFG_PHASE_Y: begin
                    r_cfg.phase_y <= $signed(i_cfg_data);
                    r_cfg.py7     <= n_py7[31:0];
                end
                wvn_pkg::CFG_WAVE_SCALE:    r_cfg.scale     <= i_cfg_data[15:0];
                wvn_pkg::CFG_AMPLITUDE:     r_cfg.amp       <= i_cfg_data[23:0];
                wvn_pkg::CFG_CELL_LENGTH:   r_cell_length   <= i_cfg_data[23:0];
                wvn_pkg::CFG_CELL_WIDTH:    r_cell_width    <= i_cfg_data[23:0];
                wvn_pkg::CFG_SECTIONS_LONG: r_sections_long <= i_cfg_data[10:0];
                wvn_pkg::CFG_SECTIONS_WIDE: r_sections_wide <= i_cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    // The normal comes from the quad whose far corner is clamped to the grid.
    always_comb begin
        n_l = (32'(r_sections_long) > 32'(MAX_SECTIONS)) ? 11'(MAX_SECTIONS)
                                                         : r_sections_long;
        n_w = (32'(r_sections_wide) > 32'(MAX_SECTIONS)) ? 11'(MAX_SECTIONS)
                                                         : r_sections_wide;
        n_a = ((12'(i_vertex_x) + 12'd1) < 12'(n_l)) ? i_vertex_x + 11'd1 : n_l;
        n_b = ((12'(i_vertex_y) + 12'd1) < 12'(n_w)) ? i_vertex_y + 11'd1 : n_w;
        n_empty = (n_l == 11'd0) || (n_w == 11'd0);
        n_px = 35'(i_vertex_x) * 35'(r_cell_length);
        n_py = 35'(i_vertex_y) * 35'(r_cell_width);
        n_side.pos_x   = n_px[34] ? {34{1'b1}} : n_px[33:0];
        n_side.pos_y   = n_py[34] ? {34{1'b1}} : n_py[33:0];
        n_side.empty   = n_empty;
        n_side.outside = n_empty || (i_vertex_x > n_l) || (i_vertex_y > n_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[SideLen-2:0], start & ~busy};
            r_valid <= r_vld[SideLen-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_hx[0] <= i_vertex_x;
        r_hy[0] <= i_vertex_y;
        r_hx[1] <= n_a;
        r_hy[1] <= n_b - 11'd1;
        r_hx[2] <= n_a - 11'd1;
        r_hy[2] <= n_b - 11'd1;
        r_hx[3] <= n_a;
        r_hy[3] <= n_b;
        r_side[0] <= n_side;
        for (int i = 1; i < SideLen; i++) begin
            r_side[i] <= r_side[i-1];
        end
        r_uz    <= 26'(w_h[2]) - 26'(w_h[1]);
        r_vz    <= 26'(w_h[1]) - 26'(w_h[3]);
        r_hd[0] <= w_h[0];
        for (int i = 1; i <= wvn_pkg::NRM_LAT; i++) begin
            r_hd[i] <= r_hd[i-1];
        end
        o_pos_x        <= r_side[SideLen-1].pos_x;
        o_pos_y        <= r_side[SideLen-1].pos_y;
        o_outside_grid <= r_side[SideLen-1].outside;
        o_height       <= r_hd[wvn_pkg::NRM_LAT];
        o_normal_x     <= w_nx;
        o_normal_y     <= w_ny;
        o_normal_z     <= w_nz;
    end

    for (genvar g = 0; g < 4; g++) begin : g_height
        wvn_height #(
            .SINE_DEPTH (SINE_DEPTH)
        ) u_height (
            .i_clk (i_clk),
            .i_x   (r_hx[g]),
            .i_y   (r_hy[g]),
            .i_cfg (r_cfg),
            .o_h   (w_h[g])
        );
    end

    wvn_normal u_normal (
        .i_clk         (i_clk),
        .i_uz          (r_uz),
        .i_vz          (r_vz),
        .i_cell_length (r_cell_length),
        .i_cell_width  (r_cell_width),
        .i_zero        (r_side[wvn_pkg::HGT_LAT + 1].empty),
        .o_nx          (w_nx),
        .o_ny          (w_ny),
        .o_nz          (w_nz)
    );

    assign o_valid = r_valid;

endmodule
`default_nettype wire

// File: tb/wave_heightfield_vertex_normal_test.sv
`timescale 1ns / 1ps
module wave_heightfield_vertex_normal_test;

    localparam int TABLE_DEPTH   = 1024;
    localparam int SECTION_LIMIT = 1024;
    localparam int PIPE_LATENCY  = 72;
    localparam int STALL_LIMIT   = 5000;

    typedef struct {
        logic [33:0]        pos_x;
        logic [33:0]        pos_y;
        logic signed [24:0] height;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic [14:0]        normal_z;
        logic               outside;
    } t_vertex_out;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [10:0]        i_vertex_x = '0;
    logic [10:0]        i_vertex_y = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               o_valid;
    logic [33:0]        o_pos_x;
    logic [33:0]        o_pos_y;
    logic signed [24:0] o_height;
    logic signed [15:0] o_normal_x;
    logic signed [15:0] o_normal_y;
    logic [14:0]        o_normal_z;
    logic               o_outside_grid;

    wave_heightfield_vertex_normal dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_vertex_x(i_vertex_x), .i_vertex_y(i_vertex_y),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_pos_x(o_pos_x), .o_pos_y(o_pos_y),
        .o_height(o_height), .o_normal_x(o_normal_x), .o_normal_y(o_normal_y),
        .o_normal_z(o_normal_z), .o_outside_grid(o_outside_grid)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the register file.
    longint          sh_phase_x, sh_phase_y;
    longint unsigned sh_scale, sh_amp, sh_len, sh_wid, sh_long, sh_wide;

    logic [14:0] sine_quarter [0:TABLE_DEPTH];
    t_vertex_out pending_vertices [$];
    int          mismatches = 0;
    int          sender_idle_pct = 0;
    int          stall_cycles = 0;

    function automatic longint half_up_shift(longint v, int sh);
        longint w;
        w = v + (64'sd1 <<< (sh - 1));
        if (w >= 0) return w >>> sh;
        return -(((-w) + ((64'sd1 <<< sh) - 1)) >>> sh);
    endfunction

    function automatic logic [14:0] series_sine(longint unsigned x);
        longint unsigned x2, p, r;
        x2 = (x * x) >> 30;
        p = wvn_pkg::ONE_Q30;
        p = wvn_pkg::ONE_Q30 - ((x2 * p) >> 30) / 110;
        p = wvn_pkg::ONE_Q30 - ((x2 * p) >> 30) / 72;
        p = wvn_pkg::ONE_Q30 - ((x2 * p) >> 30) / 42;
        p = wvn_pkg::ONE_Q30 - ((x2 * p) >> 30) / 20;
        p = wvn_pkg::ONE_Q30 - ((x2 * p) >> 30) / 6;
        r = (x * p + (64'd1 << 45)) >> 46;
        if (r > 16384) r = 16384;
        return r[14:0];
    endfunction

    function automatic logic [31:0] angle_to_turns(longint t, int extra);
        longint          m, r;
        longint unsigned prod;
        m = longint'(wvn_pkg::TWO_PI_Q30) * (extra ? 2 : 1);
        r = t % m;
        if (r < 0) r += m;
        prod = longint'(r) * wvn_pkg::INV_TWO_PI_Q32;
        prod = prod >> (30 + extra);
        return prod[31:0];
    endfunction

    function automatic longint sine_at(logic [31:0] ph);
        longint unsigned frac, idx;
        longint          s;
        frac = ph[29:0];
        idx = (frac * TABLE_DEPTH + (64'd1 << 29)) >> 30;
        if (idx > TABLE_DEPTH) idx = TABLE_DEPTH;
        if (ph[30]) idx = TABLE_DEPTH - idx;
        s = sine_quarter[idx];
        return ph[31] ? -s : s;
    endfunction

    function automatic longint wave_height_at(longint unsigned x, longint unsigned y);
        longint k, px7, py7, xs, ys, sum, h;
        k = sh_scale;
        px7 = half_up_shift(sh_phase_x * 45875, 16);
        py7 = half_up_shift(sh_phase_y * 45875, 16);
        xs = x * 65536;
        ys = y * 65536;
        sum = sine_at(angle_to_turns((xs + sh_phase_x) * k, 0) + 32'h4000_0000)
                * sine_at(angle_to_turns((ys + sh_phase_y) * k, 0))
            + sine_at(angle_to_turns((xs + px7) * k * 5, 1) + 32'h4000_0000)
                * sine_at(angle_to_turns((ys - py7) * k * 5, 1));
        h = half_up_shift(sum * longint'(sh_amp), 29);
        if (h > 16777215) h = 16777215;
        if (h < -16777216) h = -16777216;
        return h;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic t_vertex_out vertex_result(longint unsigned x, longint unsigned y);
        t_vertex_out     o;
        longint unsigned lim_l, lim_w, a, b, maxm, sq, len, q;
        longint unsigned mag [3];
        longint          c [3];
        longint          nrm [3];
        longint          htl, uz, vz;
        int              sh;
        lim_l = (sh_long > SECTION_LIMIT) ? SECTION_LIMIT : sh_long;
        lim_w = (sh_wide > SECTION_LIMIT) ? SECTION_LIMIT : sh_wide;
        nrm = '{0, 0, 0};
        if (lim_l != 0 && lim_w != 0) begin
            a = (x + 1 < lim_l) ? x + 1 : lim_l;
            b = (y + 1 < lim_w) ? y + 1 : lim_w;
            htl = wave_height_at(a, b - 1);
            uz = wave_height_at(a - 1, b - 1) - htl;
            vz = htl - wave_height_at(a, b);
            c[0] = longint'(sh_wid) * uz;
            c[1] = longint'(sh_len) * vz;
            c[2] = longint'(sh_len) * longint'(sh_wid);
            maxm = 0;
            for (int i = 0; i < 3; i++) begin
                mag[i] = (c[i] < 0) ? -c[i] : c[i];
                if (mag[i] > maxm) maxm = mag[i];
            end
            sh = 0;
            while ((maxm >> sh) >= (64'd1 << 30)) sh++;
            for (int i = 0; i < 3; i++) mag[i] >>= sh;
            sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
            // A nearly vanishing cross product gives a zero normal.
            if (!(sh == 0 && sq <= 42)) begin
                len = floor_sqrt(sq);
                if (len != 0) begin
                    for (int i = 0; i < 3; i++) begin
                        q = (mag[i] * 16384 + len / 2) / len;
                        if (q > 16384) q = 16384;
                        nrm[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
                    end
                end
            end
        end
        o.pos_x = (x * sh_len > 64'h3_FFFF_FFFF) ? 34'h3_FFFF_FFFF : 34'(x * sh_len);
        o.pos_y = (y * sh_wid > 64'h3_FFFF_FFFF) ? 34'h3_FFFF_FFFF : 34'(y * sh_wid);
        o.height = 25'(wave_height_at(x, y));
        o.normal_x = 16'(nrm[0]);
        o.normal_y = 16'(nrm[1]);
        o.normal_z = 15'(nrm[2]);
        o.outside = (lim_l == 0) || (lim_w == 0) || (x > lim_l) || (y > lim_w);
        return o;
    endfunction

    // Register writes, accepted vertices and result beats, all seen at the rising edge.
    always @(posedge i_clk) begin
        t_vertex_out want;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (wvn_pkg::t_cfg_idx'(i_cfg_index))
                wvn_pkg::CFG_PHASE_X:       sh_phase_x = longint'($signed(i_cfg_data));
                wvn_pkg::CFG_PHASE_Y:       sh_phase_y = longint'($signed(i_cfg_data));
                wvn_pkg::CFG_WAVE_SCALE:    sh_scale = i_cfg_data[15:0];
                wvn_pkg::CFG_AMPLITUDE:     sh_amp = i_cfg_data[23:0];
                wvn_pkg::CFG_CELL_LENGTH:   sh_len = i_cfg_data[23:0];
                wvn_pkg::CFG_CELL_WIDTH:    sh_wid = i_cfg_data[23:0];
                wvn_pkg::CFG_SECTIONS_LONG: sh_long = i_cfg_data[10:0];
                wvn_pkg::CFG_SECTIONS_WIDE: sh_wide = i_cfg_data[10:0];
                default: ;
            endcase
        end
        if (i_rst_n && o_valid) begin
            if (pending_vertices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
            end else begin
                want = pending_vertices.pop_front();
                if (o_pos_x !== want.pos_x || o_pos_y !== want.pos_y
                        || o_height !== want.height || o_normal_x !== want.normal_x
                        || o_normal_y !== want.normal_y || o_normal_z !== want.normal_z
                        || o_outside_grid !== want.outside) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected pos %0d,%0d h %0d n %0d,%0d,%0d out %0b",
                            want.pos_x, want.pos_y, want.height, want.normal_x,
                            want.normal_y, want.normal_z, want.outside);
                        $display("          actual   pos %0d,%0d h %0d n %0d,%0d,%0d out %0b",
                            o_pos_x, o_pos_y, o_height, o_normal_x, o_normal_y,
                            o_normal_z, o_outside_grid);
                    end
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            pending_vertices.push_back(vertex_result(64'(i_vertex_x), 64'(i_vertex_y)));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || (i_cfg_valid && o_cfg_ready) || o_valid) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_vertex(input logic [10:0] x, input logic [10:0] y);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start = 1'b1;
        i_vertex_x = x;
        i_vertex_y = y;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Lets the pipeline empty so the registers can be changed safely.
    task automatic drain_pipeline();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_vertices.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(input wvn_pkg::t_cfg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_vertex(11'd0, 11'd0);
        send_vertex(11'd16, 11'd16);
        send_vertex(11'd15, 11'd3);
        send_vertex(11'd17, 11'd0);
        send_vertex(11'd0, 11'd17);
        send_vertex(11'h7FF, 11'h7FF);
        drain_pipeline();
    endtask

    task automatic test_extreme_registers();
        write_reg(wvn_pkg::CFG_PHASE_X, 32'h7FFF_FFFF);
        write_reg(wvn_pkg::CFG_PHASE_Y, 32'h8000_0000);
        write_reg(wvn_pkg::CFG_WAVE_SCALE, 32'h0000_FFFF);
        write_reg(wvn_pkg::CFG_AMPLITUDE, 32'h00FF_FFFF);
        write_reg(wvn_pkg::CFG_CELL_LENGTH, 32'h00FF_FFFF);
        write_reg(wvn_pkg::CFG_CELL_WIDTH, 32'h00FF_FFFF);
        // Counts above the section limit are clamped by the block.
        write_reg(wvn_pkg::CFG_SECTIONS_LONG, 32'd2047);
        write_reg(wvn_pkg::CFG_SECTIONS_WIDE, 32'd1024);
        send_vertex(11'd0, 11'd0);
        send_vertex(11'd1024, 11'd1024);
        send_vertex(11'd1023, 11'd1);
        send_vertex(11'h7FF, 11'd0);
        send_vertex(11'h555, 11'h2AA);
        drain_pipeline();
        write_reg(wvn_pkg::CFG_PHASE_X, 32'h8000_0000);
        write_reg(wvn_pkg::CFG_PHASE_Y, 32'h7FFF_FFFF);
        write_reg(wvn_pkg::CFG_WAVE_SCALE, 32'd0);
        write_reg(wvn_pkg::CFG_AMPLITUDE, 32'd0);
        write_reg(wvn_pkg::CFG_SECTIONS_LONG, 32'd1);
        write_reg(wvn_pkg::CFG_SECTIONS_WIDE, 32'd1);
        send_vertex(11'd0, 11'd0);
        send_vertex(11'd1, 11'd1);
        send_vertex(11'd2, 11'd0);
        drain_pipeline();
    endtask

    task automatic test_degenerate_and_empty();
        // Zero cell length zeroes the y and z components of the cross product.
        write_reg(wvn_pkg::CFG_CELL_LENGTH, 32'd0);
        write_reg(wvn_pkg::CFG_AMPLITUDE, 32'd25600);
        write_reg(wvn_pkg::CFG_WAVE_SCALE, 32'd1638);
        send_vertex(11'd0, 11'd0);
        send_vertex(11'd1, 11'd0);
        drain_pipeline();
        write_reg(wvn_pkg::CFG_CELL_LENGTH, 32'd2);
        write_reg(wvn_pkg::CFG_CELL_WIDTH, 32'd3);
        send_vertex(11'd0, 11'd1);
        drain_pipeline();
        // An empty grid still reports position and height.
        write_reg(wvn_pkg::CFG_SECTIONS_LONG, 32'd0);
        send_vertex(11'd0, 11'd0);
        send_vertex(11'd5, 11'd1);
        drain_pipeline();
        write_reg(wvn_pkg::CFG_SECTIONS_LONG, 32'd8);
        write_reg(wvn_pkg::CFG_SECTIONS_WIDE, 32'd0);
        send_vertex(11'd3, 11'd0);
        drain_pipeline();
    endtask

    task automatic load_random_registers();
        int pick;
        write_reg(wvn_pkg::CFG_PHASE_X, $urandom);
        write_reg(wvn_pkg::CFG_PHASE_Y, $urandom);
        write_reg(wvn_pkg::CFG_WAVE_SCALE,
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(4000));
        write_reg(wvn_pkg::CFG_AMPLITUDE,
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(60000));
        write_reg(wvn_pkg::CFG_CELL_LENGTH,
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(8000));
        write_reg(wvn_pkg::CFG_CELL_WIDTH,
                  ($urandom_range(3) == 0) ? $urandom : $urandom_range(8000));
        pick = $urandom_range(9);
        write_reg(wvn_pkg::CFG_SECTIONS_LONG, (pick == 0) ? $urandom : (pick == 1) ? 1024
                                              : $urandom_range(1, 32));
        pick = $urandom_range(9);
        write_reg(wvn_pkg::CFG_SECTIONS_WIDE, (pick == 0) ? $urandom : (pick == 1) ? 1024
                                              : $urandom_range(1, 32));
    endtask

    task automatic test_random_grid(input int idle_pct);
        int lim_l, lim_w;
        sender_idle_pct = idle_pct;
        for (int set = 0; set < 4; set++) begin
            load_random_registers();
            lim_l = (sh_long > SECTION_LIMIT) ? SECTION_LIMIT : int'(sh_long);
            lim_w = (sh_wide > SECTION_LIMIT) ? SECTION_LIMIT : int'(sh_wide);
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(9) == 0) begin
                    send_vertex(11'($urandom), 11'($urandom));
                end else begin
                    send_vertex(11'($urandom_range(lim_l + 1)),
                                11'($urandom_range(lim_w + 1)));
                end
                if ($urandom_range(149) == 0) begin
                    @(negedge i_clk);
                    start = 1'b0;
                    while (pending_vertices.size() != 0) @(posedge i_clk);
                end
            end
            drain_pipeline();
        end
    endtask

    initial begin
        for (int i = 0; i <= TABLE_DEPTH; i++) begin
            sine_quarter[i] = series_sine((wvn_pkg::HALF_PI_Q30 * i) / TABLE_DEPTH);
        end
        sh_phase_x = 0;
        sh_phase_y = 0;
        sh_scale = wvn_pkg::RST_WAVE_SCALE;
        sh_amp = wvn_pkg::RST_AMPLITUDE;
        sh_len = wvn_pkg::RST_CELL_LENGTH;
        sh_wid = wvn_pkg::RST_CELL_WIDTH;
        sh_long = wvn_pkg::RST_SECTIONS_LONG;
        sh_wide = wvn_pkg::RST_SECTIONS_WIDE;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_extreme_registers();
        test_degenerate_and_empty();
        test_random_grid(20);
        test_random_grid(70);
        test_random_grid(0);

        drain_pipeline();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// File: sim.f
design/wvn_pkg.sv
design/wvn_height.sv
design/wvn_normal.sv
design/wave_heightfield_vertex_normal.sv
tb/wave_heightfield_vertex_normal_test.sv
